### sv/c3sf_pkg.sv
// ----------------------------------------------------------------------------
// c3sf_pkg - shared types and constants of the 3x3 stream filter
// Field widths, register indexes and the result entry type.
// ----------------------------------------------------------------------------
package c3sf_pkg;

    localparam int PIX_W    = 8;
    localparam int OUT_W    = 16;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int COEF_W   = 16;
    localparam int CPACK_W  = 48;
    localparam int CFG_IDX_W = 3;

    localparam int CMD_PIXEL = 0;
    localparam int CMD_FLUSH = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LEFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RIGHT   = 3'd4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;
    localparam logic [CPACK_W-1:0]  COEF_LEFT_RESET  = 48'd0;
    localparam logic [CPACK_W-1:0]  COEF_MID_RESET   = 48'd256;
    localparam logic [CPACK_W-1:0]  COEF_RIGHT_RESET = 48'd0;

    // product of a Q8.8 tap and an unsigned pixel, and the nine-term sum
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = PROD_W + 4;
    localparam int Q_W    = ACC_W - 8;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic signed [OUT_W-1:0] pixel_out;
        logic                    saturated;
        logic                    last_of_frame;
    } t_out_item;

endpackage

### sv/c3sf_ifs.sv
// ----------------------------------------------------------------------------
// c3sf interfaces - pixel, result and configuration channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface c3sf_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [c3sf_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output command, output pixel_in, input ready);
    modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

interface c3sf_pix_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [c3sf_pkg::OUT_W-1:0]  pixel_out;
    logic                               saturated;
    logic                               last_of_frame;

    modport source (output valid, output pixel_out, output saturated,
                    output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input saturated,
                    input last_of_frame, output ready);
endinterface

interface c3sf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [c3sf_pkg::CFG_IDX_W-1:0]   index;
    logic [c3sf_pkg::CPACK_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/conv3x3_stream_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_stream_filter - 3x3 convolution over a raster pixel stream
// Two line memories and a 3x3 window; interior pixels are filtered with
// signed Q8.8 taps, border pixels pass through.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_pix     in   valid/ready    command, pixel_in
//  o_pix     out  valid/ready    pixel_out, saturated, last_of_frame
//  i_cfg     in   valid/ready    index, data (always ready)
//
//  One request is taken per cycle while ready is high; the line memories are
//  read on acceptance and written back the next cycle, so a request completes
//  in one memory round trip. A completed window then passes the product, sum
//  and saturation stages (the centre pixel lags the input by frame_width+1
//  requests). Results queue in an eight-entry output buffer; i_pix.ready
//  drops only when the buffer plus the requests in flight would overflow it.
//  Reset clears control state only; there is no memory clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_stream_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    c3sf_pix_in_if.sink        i_pix,
    c3sf_pix_out_if.source     o_pix,
    c3sf_cfg_if.sink           i_cfg
);

    localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (PW + 1 > c3sf_pkg::WIDTH_W) ? PW + 1 : c3sf_pkg::WIDTH_W;
    localparam int PIX_W = c3sf_pkg::PIX_W;

    // configuration registers
    logic [c3sf_pkg::WIDTH_W-1:0]   r_width;
    logic [c3sf_pkg::HEIGHT_W-1:0]  r_height;
    logic [c3sf_pkg::CPACK_W-1:0]   r_coef [3];

    // line memories: lower entries carry a pixel-present bit above the pixel
    logic [PIX_W-1:0]  mem_upper [MAX_WIDTH];
    logic [PIX_W:0]    mem_lower [MAX_WIDTH];
    logic [PIX_W-1:0]  r_q_top;
    logic [PIX_W:0]    r_q_mid;

    logic [PW-1:0]  r_col;
    logic [LW-1:0]  r_lag_count;

    // stage 1: memory read in flight
    logic              r1_v;
    logic [PIX_W-1:0]  r1_pix;
    logic              r1_ok;
    logic [PW-1:0]     r1_p;
    logic              r1_wr;

    // window and output position
    logic [PIX_W-1:0]  r_win [3][3];
    logic              r_mid_ok;
    logic [c3sf_pkg::WIDTH_W-1:0]   r_out_col;
    logic [c3sf_pkg::HEIGHT_W-1:0]  r_out_row;

    // stage 2..4
    logic              r2_v, r3_v, r4_v;
    logic              r2_border, r3_border, r4_border;
    logic              r2_last, r3_last, r4_last;
    logic [PIX_W-1:0]  r2_centre, r3_centre, r4_centre;
    c3sf_pkg::t_prod   r3_prod [9];
    c3sf_pkg::t_acc    r4_acc;

    // output buffer
    c3sf_pkg::t_out_item               r_fifo [c3sf_pkg::OUT_DEPTH];
    logic [c3sf_pkg::OUT_PTR_W-1:0]    r_head, r_tail;
    logic [c3sf_pkg::OUT_CNT_W-1:0]    r_cnt;

    logic           accept, pop, push;
    logic [XW-1:0]  col_x, width_x, p_inc;
    logic [PW-1:0]  p_now, n_col;
    logic           p_written;
    logic [LW-1:0]  n_lag_count;
    logic [c3sf_pkg::OUT_CNT_W-1:0] inflight;

    assign accept = i_pix.valid && i_pix.ready;
    assign pop    = o_pix.valid && o_pix.ready;
    assign push   = r4_v;

    assign inflight = c3sf_pkg::OUT_CNT_W'(r1_v) + c3sf_pkg::OUT_CNT_W'(r2_v)
                    + c3sf_pkg::OUT_CNT_W'(r3_v) + c3sf_pkg::OUT_CNT_W'(r4_v);
    assign i_pix.ready = (r_cnt + inflight) < c3sf_pkg::OUT_CNT_W'(c3sf_pkg::OUT_DEPTH);
    assign i_cfg.ready = 1'b1;

    // ---------------- configuration ----------------
    logic [XW-1:0] cfg_w;
    assign cfg_w = XW'(i_cfg.data[c3sf_pkg::WIDTH_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= c3sf_pkg::WIDTH_RESET;
            r_height  <= c3sf_pkg::HEIGHT_RESET;
            r_coef[0] <= c3sf_pkg::COEF_LEFT_RESET;
            r_coef[1] <= c3sf_pkg::COEF_MID_RESET;
            r_coef[2] <= c3sf_pkg::COEF_RIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                c3sf_pkg::REG_FRAME_WIDTH: begin
                    if (cfg_w < XW'(c3sf_pkg::WIDTH_MIN))
                        r_width <= c3sf_pkg::WIDTH_MIN;
                    else if (cfg_w > XW'(MAX_WIDTH))
                        r_width <= c3sf_pkg::WIDTH_W'(MAX_WIDTH);
                    else
                        r_width <= i_cfg.data[c3sf_pkg::WIDTH_W-1:0];
                end
                c3sf_pkg::REG_FRAME_HEIGHT: begin
                    if (i_cfg.data[c3sf_pkg::HEIGHT_W-1:0] < c3sf_pkg::HEIGHT_MIN)
                        r_height <= c3sf_pkg::HEIGHT_MIN;
                    else
                        r_height <= i_cfg.data[c3sf_pkg::HEIGHT_W-1:0];
                end
                c3sf_pkg::REG_COEF_LEFT:  r_coef[0] <= i_cfg.data;
                c3sf_pkg::REG_COEF_MID:   r_coef[1] <= i_cfg.data;
                c3sf_pkg::REG_COEF_RIGHT: r_coef[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: pointer and memory read ----------------
    always_comb begin
        col_x   = XW'(r_col);
        width_x = XW'(r_width);
        p_now   = (col_x >= width_x) ? '0 : r_col;
        p_inc   = XW'(p_now) + XW'(1);
        n_col   = (p_inc >= width_x) ? '0 : p_inc[PW-1:0];
        // entries below the lag count have been written since reset
        p_written   = LW'(p_now) < r_lag_count;
        n_lag_count = (LW'(p_inc) > r_lag_count) ? LW'(p_inc) : r_lag_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_lag_count <= '0;
            r1_v        <= 1'b0;
        end else begin
            r1_v <= accept;
            if (accept) begin
                r_col       <= n_col;
                r_lag_count <= n_lag_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pix <= (i_pix.command == 1'(c3sf_pkg::CMD_FLUSH)) ? '0 : i_pix.pixel_in;
            r1_ok  <= (i_pix.command == 1'(c3sf_pkg::CMD_PIXEL));
            r1_p   <= p_now;
            r1_wr  <= p_written;
        end
    end

    // consecutive requests never share an entry, so write-back needs no bypass
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_top <= mem_upper[p_now];
            r_q_mid <= mem_lower[p_now];
        end
        if (r1_v) begin
            mem_upper[r1_p] <= r_q_mid[PIX_W-1:0];
            mem_lower[r1_p] <= {r1_ok, r1_pix};
        end
    end

    // ---------------- stage 1: window shift and position ----------------
    logic [c3sf_pkg::WIDTH_W-1:0]   col_e;
    logic [c3sf_pkg::HEIGHT_W-1:0]  row_e;
    logic [c3sf_pkg::WIDTH_W:0]     col_inc;
    logic [c3sf_pkg::HEIGHT_W:0]    row_inc;
    logic                           emit, border, last;

    always_comb begin
        emit    = r1_v && r_mid_ok;
        col_e   = (r_out_col >= r_width) ? '0 : r_out_col;
        row_e   = (r_out_row >= r_height) ? '0 : r_out_row;
        border  = (row_e == '0) || (row_e == r_height - 1'b1)
               || (col_e == '0) || (col_e == r_width - 1'b1);
        last    = (row_e == r_height - 1'b1) && (col_e == r_width - 1'b1);
        col_inc = {1'b0, col_e} + 1'b1;
        row_inc = {1'b0, row_e} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_ok  <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r2_v      <= 1'b0;
        end else begin
            r2_v <= emit;
            if (r1_v)
                r_mid_ok <= r_q_mid[PIX_W] && r1_wr;
            if (emit) begin
                if (col_inc >= {1'b0, r_width}) begin
                    r_out_col <= '0;
                    r_out_row <= (row_inc >= {1'b0, r_height})
                               ? '0 : row_inc[c3sf_pkg::HEIGHT_W-1:0];
                end else begin
                    r_out_col <= col_inc[c3sf_pkg::WIDTH_W-1:0];
                    r_out_row <= row_e;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_v) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_q_top;
            r_win[1][2] <= r_q_mid[PIX_W-1:0];
            r_win[2][2] <= r1_pix;
        end
        r2_border <= border;
        r2_last   <= last;
        r2_centre <= r_win[1][2];
    end

    // ---------------- stage 2: nine products ----------------
    c3sf_pkg::t_prod prod [9];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod[r*3+c] = c3sf_pkg::PROD_W'(
                    $signed(r_coef[c][c3sf_pkg::COEF_W*r +: c3sf_pkg::COEF_W])
                    * $signed({1'b0, r_win[r][c]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r3_v <= 1'b0;
        else
            r3_v <= r2_v;
        r3_prod   <= prod;
        r3_border <= r2_border;
        r3_last   <= r2_last;
        r3_centre <= r2_centre;
    end

    // ---------------- stage 3: sum ----------------
    c3sf_pkg::t_acc acc;

    always_comb begin
        acc = '0;
        for (int k = 0; k < 9; k++)
            acc = acc + c3sf_pkg::ACC_W'(r3_prod[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r4_v <= 1'b0;
        else
            r4_v <= r3_v;
        r4_acc    <= acc;
        r4_border <= r3_border;
        r4_last   <= r3_last;
        r4_centre <= r3_centre;
    end

    // ---------------- stage 4: truncate, saturate ----------------
    c3sf_pkg::t_acc          acc_adj;
    logic signed [c3sf_pkg::Q_W-1:0] q;
    c3sf_pkg::t_out_item     res;

    always_comb begin
        // round toward zero: bias negative sums before the shift
        acc_adj = r4_acc + (r4_acc[c3sf_pkg::ACC_W-1]
                  ? c3sf_pkg::ACC_W'(255) : c3sf_pkg::ACC_W'(0));
        q = acc_adj[c3sf_pkg::ACC_W-1:8];
        res.last_of_frame = r4_last;
        if (r4_border) begin
            res.pixel_out = $signed({{(c3sf_pkg::OUT_W-PIX_W){1'b0}}, r4_centre});
            res.saturated = 1'b0;
        end else if (q > $signed(c3sf_pkg::Q_W'(32767))) begin
            res.pixel_out = 16'sh7FFF;
            res.saturated = 1'b1;
        end else if (q < -$signed(c3sf_pkg::Q_W'(32768))) begin
            res.pixel_out = -16'sh8000;
            res.saturated = 1'b1;
        end else begin
            res.pixel_out = q[c3sf_pkg::OUT_W-1:0];
            res.saturated = 1'b0;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (push)
                r_tail <= r_tail + 1'b1;
            if (pop)
                r_head <= r_head + 1'b1;
            r_cnt <= r_cnt + c3sf_pkg::OUT_CNT_W'(push) - c3sf_pkg::OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_fifo[r_tail] <= res;
    end

    assign o_pix.valid         = (r_cnt != '0);
    assign o_pix.pixel_out     = r_fifo[r_head].pixel_out;
    assign o_pix.saturated     = r_fifo[r_head].saturated;
    assign o_pix.last_of_frame = r_fifo[r_head].last_of_frame;

    // ---------------- assertions ----------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < c3sf_pkg::OUT_CNT_W'(c3sf_pkg::OUT_DEPTH)) || pop)
        else $error("output buffer overflow");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt + inflight) <= c3sf_pkg::OUT_CNT_W'(c3sf_pkg::OUT_DEPTH))
        else $error("requests in flight exceed buffer room");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r1_v) |-> (p_now != r1_p))
        else $error("read and write-back hit the same line entry");

    a_emit_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> $past(r1_v))
        else $error("result started without a request");

endmodule

### tb/c3sf_checker.sv
// ----------------------------------------------------------------------------
// c3sf_checker - result predictor and scoreboard of the 3x3 stream filter
// Watches the pixel, result and configuration channels, mirrors the line
// stores and the window, and compares every result with the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module c3sf_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    c3sf_pix_in_if  i_pix,
    c3sf_pix_out_if i_res,
    c3sf_cfg_if     i_cfg,
    output int      o_errors,
    output int      o_pending
);

    localparam int HEIGHT_MAX = 4095;

    logic [c3sf_pkg::PIX_W-1:0] upper_pix [MAX_WIDTH];
    logic [c3sf_pkg::PIX_W-1:0] lower_pix [MAX_WIDTH];
    bit                         upper_ok  [MAX_WIDTH];
    bit                         lower_ok  [MAX_WIDTH];
    logic [c3sf_pkg::PIX_W-1:0] win_pix   [3][3];
    bit                         win_ok    [3][3];

    int unsigned                  store_col;
    int unsigned                  next_col;
    int unsigned                  next_row;
    int unsigned                  frame_w;
    int unsigned                  frame_h;
    logic [c3sf_pkg::CPACK_W-1:0] taps_left;
    logic [c3sf_pkg::CPACK_W-1:0] taps_mid;
    logic [c3sf_pkg::CPACK_W-1:0] taps_right;

    c3sf_pkg::t_out_item pending_pixels [$];
    int                  mismatches = 0;

    assign o_errors = mismatches;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint tap_of(logic [c3sf_pkg::CPACK_W-1:0] packed_taps,
                                      int slot);
        logic signed [c3sf_pkg::COEF_W-1:0] c;
        c = packed_taps[c3sf_pkg::COEF_W*slot +: c3sf_pkg::COEF_W];
        return longint'(c);
    endfunction

    function automatic longint window_sum();
        longint acc;
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            acc += tap_of(taps_left, r)  * longint'(win_pix[r][0]);
            acc += tap_of(taps_mid, r)   * longint'(win_pix[r][1]);
            acc += tap_of(taps_right, r) * longint'(win_pix[r][2]);
        end
        return acc;
    endfunction

    task automatic clear_state();
        frame_w    = c3sf_pkg::WIDTH_RESET;
        frame_h    = c3sf_pkg::HEIGHT_RESET;
        taps_left  = c3sf_pkg::COEF_LEFT_RESET;
        taps_mid   = c3sf_pkg::COEF_MID_RESET;
        taps_right = c3sf_pkg::COEF_RIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_pix[i] = '0;
            lower_pix[i] = '0;
            upper_ok[i]  = 1'b0;
            lower_ok[i]  = 1'b0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win_pix[r][c] = '0;
                win_ok[r][c]  = 1'b0;
            end
        end
        store_col = 0;
        next_col  = 0;
        next_row  = 0;
        pending_pixels.delete();
    endtask

    task automatic write_register(logic [c3sf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [c3sf_pkg::CPACK_W-1:0] data);
        case (idx)
            c3sf_pkg::REG_FRAME_WIDTH:
                frame_w = clamp_to(data[c3sf_pkg::WIDTH_W-1:0], c3sf_pkg::WIDTH_MIN,
                                   MAX_WIDTH);
            c3sf_pkg::REG_FRAME_HEIGHT:
                frame_h = clamp_to(data[c3sf_pkg::HEIGHT_W-1:0], c3sf_pkg::HEIGHT_MIN,
                                   HEIGHT_MAX);
            c3sf_pkg::REG_COEF_LEFT:  taps_left  = data;
            c3sf_pkg::REG_COEF_MID:   taps_mid   = data;
            c3sf_pkg::REG_COEF_RIGHT: taps_right = data;
            default: ;
        endcase
    endtask

    // read both stores at the column, move the column up one row, shift the window
    task automatic shift_window(logic [c3sf_pkg::PIX_W-1:0] v, bit ok);
        int unsigned                p;
        logic [c3sf_pkg::PIX_W-1:0] above_v;
        logic [c3sf_pkg::PIX_W-1:0] row_v;
        bit                         above_ok;
        bit                         row_ok;
        p = store_col;
        if (p >= frame_w || p >= MAX_WIDTH) p = 0;
        above_v  = upper_pix[p];
        above_ok = upper_ok[p];
        row_v    = lower_pix[p];
        row_ok   = lower_ok[p];
        upper_pix[p] = row_v;
        upper_ok[p]  = row_ok;
        lower_pix[p] = v;
        lower_ok[p]  = ok;
        for (int r = 0; r < 3; r++) begin
            win_pix[r][0] = win_pix[r][1];
            win_ok[r][0]  = win_ok[r][1];
            win_pix[r][1] = win_pix[r][2];
            win_ok[r][1]  = win_ok[r][2];
        end
        win_pix[0][2] = above_v;
        win_ok[0][2]  = above_ok;
        win_pix[1][2] = row_v;
        win_ok[1][2]  = row_ok;
        win_pix[2][2] = v;
        win_ok[2][2]  = ok;
        p++;
        if (p >= frame_w) p = 0;
        store_col = p;
    endtask

    task automatic predict_pixel(logic cmd, logic [c3sf_pkg::PIX_W-1:0] pix);
        bit                  is_flush;
        bit                  on_border;
        longint              q;
        c3sf_pkg::t_out_item item;
        is_flush = (cmd == 1'(c3sf_pkg::CMD_FLUSH));
        shift_window(is_flush ? '0 : pix, !is_flush);
        // an empty centre slot yields nothing
        if (!win_ok[1][1]) return;
        if (next_col >= frame_w) next_col = 0;
        if (next_row >= frame_h) next_row = 0;
        on_border = (next_row == 0) || (next_row == frame_h - 1) ||
                    (next_col == 0) || (next_col == frame_w - 1);
        item.saturated = 1'b0;
        if (on_border) begin
            item.pixel_out = {{(c3sf_pkg::OUT_W-c3sf_pkg::PIX_W){1'b0}}, win_pix[1][1]};
        end else begin
            q = window_sum() / 256;
            if (q > 32767) begin
                q = 32767;
                item.saturated = 1'b1;
            end
            if (q < -32768) begin
                q = -32768;
                item.saturated = 1'b1;
            end
            item.pixel_out = q[c3sf_pkg::OUT_W-1:0];
        end
        item.last_of_frame = (next_row == frame_h - 1) && (next_col == frame_w - 1);
        next_col++;
        if (next_col >= frame_w) begin
            next_col = 0;
            next_row++;
            if (next_row >= frame_h) next_row = 0;
        end
        pending_pixels.insert(pending_pixels.size(), item);
    endtask

    task automatic check_field(string name, logic signed [c3sf_pkg::OUT_W:0] want,
                               logic signed [c3sf_pkg::OUT_W:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result();
        c3sf_pkg::t_out_item want;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
                     $time, i_res.pixel_out, i_res.saturated, i_res.last_of_frame);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        check_field("pixel_out", want.pixel_out, i_res.pixel_out);
        check_field("saturated", want.saturated, i_res.saturated);
        check_field("last_of_frame", want.last_of_frame, i_res.last_of_frame);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg.valid && i_cfg.ready) write_register(i_cfg.index, i_cfg.data);
            if (i_pix.valid && i_pix.ready) predict_pixel(i_pix.command, i_pix.pixel_in);
            if (i_res.valid && i_res.ready) compare_result();
        end
        o_pending <= pending_pixels.size();
    end

endmodule

### tb/conv3x3_stream_filter_test.sv
// ----------------------------------------------------------------------------
// conv3x3_stream_filter_test - stimulus and verdict for the 3x3 stream filter
// Warms the line stores over the widest random frame, runs directed requests
// for register clamping, saturation and flushes, then random frames with
// random geometry and taps. Both channel sides idle at random; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module conv3x3_stream_filter_test;

    localparam int MAX_W          = 1024;
    localparam int WARM_W         = 40;
    localparam int CLAMP_PIXELS   = 24;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_PIXELS  = 360;
    localparam logic [c3sf_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    localparam logic [c3sf_pkg::CPACK_W-1:0] TAPS_POS_MAX = {3{16'h7FFF}};
    localparam logic [c3sf_pkg::CPACK_W-1:0] TAPS_NEG_MAX = {3{16'h8000}};

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   errors;
    int   pending;
    int   send_calm = 0;
    int   sink_calm = 0;
    int   sink_hold = 0;

    c3sf_pix_in_if  pix_if ();
    c3sf_pix_out_if res_if ();
    c3sf_cfg_if     cfg_if ();

    conv3x3_stream_filter #(.MAX_WIDTH(MAX_W)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_pix   (res_if),
        .i_cfg   (cfg_if)
    );

    c3sf_checker #(.MAX_WIDTH(MAX_W)) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if),
        .i_res     (res_if),
        .i_cfg     (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long, and now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            sink_hold = pick_gap(sink_calm);
        end
    end

    function automatic logic [c3sf_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return c3sf_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [c3sf_pkg::CPACK_W-1:0] rand_taps();
        logic [c3sf_pkg::CPACK_W-1:0] t;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 9))
                0:       t[c3sf_pkg::COEF_W*k +: c3sf_pkg::COEF_W] = 16'h7FFF;
                1:       t[c3sf_pkg::COEF_W*k +: c3sf_pkg::COEF_W] = 16'h8000;
                2, 3:    t[c3sf_pkg::COEF_W*k +: c3sf_pkg::COEF_W] =
                             c3sf_pkg::COEF_W'($urandom);
                default: t[c3sf_pkg::COEF_W*k +: c3sf_pkg::COEF_W] =
                             c3sf_pkg::COEF_W'($urandom_range(0, 1023) - 512);
            endcase
        end
        return t;
    endfunction

    // a request of its own per pixel; valid stays high across back-to-back requests
    task automatic send_item(logic cmd, logic [c3sf_pkg::PIX_W-1:0] pix);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.command  <= cmd;
        pix_if.pixel_in <= pix;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    task automatic send_pixels(int n, int flush_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < flush_pct)
                send_item(1'(c3sf_pkg::CMD_FLUSH), rand_pixel());
            send_item(1'(c3sf_pkg::CMD_PIXEL), rand_pixel());
        end
    endtask

    // push one row plus one of flushes so the last pixels reach the centre
    task automatic drain(int w);
        for (int i = 0; i <= w; i++) send_item(1'(c3sf_pkg::CMD_FLUSH), rand_pixel());
    endtask

    task automatic wait_results();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [c3sf_pkg::CFG_IDX_W-1:0] idx,
                             logic [c3sf_pkg::CPACK_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [c3sf_pkg::CPACK_W-1:0] w_data,
                                logic [c3sf_pkg::CPACK_W-1:0] h_data,
                                logic [c3sf_pkg::CPACK_W-1:0] left,
                                logic [c3sf_pkg::CPACK_W-1:0] mid,
                                logic [c3sf_pkg::CPACK_W-1:0] right);
        write_reg(c3sf_pkg::REG_FRAME_WIDTH, w_data);
        write_reg(c3sf_pkg::REG_FRAME_HEIGHT, h_data);
        write_reg(c3sf_pkg::REG_COEF_LEFT, left);
        write_reg(c3sf_pkg::REG_COEF_MID, mid);
        write_reg(c3sf_pkg::REG_COEF_RIGHT, right);
        // unused indexes must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE + c3sf_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                      c3sf_pkg::CPACK_W'({$urandom, $urandom}));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [c3sf_pkg::CPACK_W-1:0] with_noise(int field_w, int value);
        logic [c3sf_pkg::CPACK_W-1:0] d;
        d = c3sf_pkg::CPACK_W'({$urandom, $urandom});
        for (int b = 0; b < field_w; b++) d[b] = value[b];
        return d;
    endfunction

    initial begin : stimulus
        int w;
        int h;
        int n;
        int phase;
        int pix_sent;
        i_rst_n         <= 1'b0;
        pix_if.valid    <= 1'b0;
        pix_if.command  <= 1'b0;
        pix_if.pixel_in <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write every store entry that a random frame can reach before it is used;
        // height below range clamps to three
        program_regs(with_noise(c3sf_pkg::WIDTH_W, WARM_W),
                     with_noise(c3sf_pkg::HEIGHT_W, 0),
                     rand_taps(), rand_taps(), rand_taps());
        send_pixels(WARM_W * 3, 0);
        drain(WARM_W);
        wait_idle();

        // width above range clamps to the maximum, so a short run yields nothing
        program_regs(with_noise(c3sf_pkg::WIDTH_W, 2047),
                     with_noise(c3sf_pkg::HEIGHT_W, 3),
                     rand_taps(), rand_taps(), rand_taps());
        send_pixels(CLAMP_PIXELS, 0);
        wait_idle();

        // positive saturation on a minimal frame
        program_regs(with_noise(c3sf_pkg::WIDTH_W, 0), with_noise(c3sf_pkg::HEIGHT_W, 2),
                     TAPS_POS_MAX, TAPS_POS_MAX, TAPS_POS_MAX);
        for (int i = 0; i < 9; i++) send_item(1'(c3sf_pkg::CMD_PIXEL), 8'hFF);
        drain(3);
        wait_idle();

        // negative saturation, a flush on the empty pipeline and one mid-frame
        program_regs(48'd3, 48'h1003, TAPS_NEG_MAX, TAPS_NEG_MAX, TAPS_NEG_MAX);
        send_item(1'(c3sf_pkg::CMD_FLUSH), 8'hFF);
        send_item(1'(c3sf_pkg::CMD_PIXEL), 8'h00);
        for (int i = 0; i < 3; i++) send_item(1'(c3sf_pkg::CMD_PIXEL), 8'hFF);
        send_item(1'(c3sf_pkg::CMD_FLUSH), 8'h00);
        for (int i = 0; i < 4; i++) send_item(1'(c3sf_pkg::CMD_PIXEL), 8'hFF);
        send_item(1'(c3sf_pkg::CMD_PIXEL), 8'h00);
        drain(3);
        wait_idle();

        pix_sent = 0;
        phase    = 0;
        while (pix_sent < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(11, WARM_W)
                                            : $urandom_range(3, 10);
            h = $urandom_range(3, 5);
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 7) == 0) begin
                h = 4095;
                n = w * $urandom_range(2, 5);
            end
            // a partial frame leaves positions mid-frame for the next geometry
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            if (n > 160) n = 160;
            program_regs(with_noise(c3sf_pkg::WIDTH_W, w), with_noise(c3sf_pkg::HEIGHT_W, h),
                         rand_taps(), rand_taps(), rand_taps());
            if (phase == 1 || $urandom_range(0, 4) == 0) begin
                send_pixels(n / 2, 5);
                wait_results();
                send_pixels(n - n / 2, 5);
            end else begin
                send_pixels(n, 5);
            end
            drain(w);
            wait_idle();
            pix_sent += n;
            phase++;
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
